### design/brqe_pkg.sv
// ----------------------------------------------------------------------------
// brqe_pkg
// Shared types, widths, request codes and the popcount function of the
// bit-vector rank query engine.
// ----------------------------------------------------------------------------
`default_nettype none

package brqe_pkg;

  localparam int DEF_MAX_BITS        = 65536;
  localparam int DEF_SAMPLE_INTERVAL = 512;

  localparam int WORD_W  = 64;
  localparam int BIT_W   = 6;
  localparam int VALID_W = 7;
  localparam int POS_W   = 32;
  localparam int SHIFT_W = 17;
  localparam int POP_W   = 7;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_QSTART,
    ST_QRUN,
    ST_FINISH
  } state_t;

  function automatic logic [POP_W-1:0] popcount64(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
    logic [WORD_W-1:0] e;
    logic [WORD_W-1:0] f;
    a = (x & 64'h5555_5555_5555_5555) + ((x >> 1) & 64'h5555_5555_5555_5555);
    b = (a & 64'h3333_3333_3333_3333) + ((a >> 2) & 64'h3333_3333_3333_3333);
    c = (b & 64'h0F0F_0F0F_0F0F_0F0F) + ((b >> 4) & 64'h0F0F_0F0F_0F0F_0F0F);
    d = (c & 64'h00FF_00FF_00FF_00FF) + ((c >> 8) & 64'h00FF_00FF_00FF_00FF);
    e = (d & 64'h0000_FFFF_0000_FFFF) + ((d >> 16) & 64'h0000_FFFF_0000_FFFF);
    f = (e & 64'h0000_0000_FFFF_FFFF) + (e >> 32);
    return f[POP_W-1:0];
  endfunction

endpackage

`default_nettype wire

### design/bitvector_rank_query_engine.sv
// ----------------------------------------------------------------------------
// bitvector_rank_query_engine
// Bit-vector store with sampled rank counts; answers load and rank requests.
// ----------------------------------------------------------------------------
// Items are handled one at a time. A load goes through transfer, update of
// the bit store, sample store and counters, then handoff to the output
// register. A rank query goes through transfer, a start step that reads the
// sample and the first word, a scan of k words from the start of the
// position's sample interval up to and including the position's word (1 to
// SAMPLE_INTERVAL/64, 8 at the defaults), then handoff; the bit store has one
// read port and one word is counted per cycle. A query past the stored length
// skips the scan. The output register frees the input side as soon as a
// result is handed off. MAX_BITS and SAMPLE_INTERVAL must be powers of two,
// at least 64. Both memories come up undefined and need no clearing pass;
// only words and samples written since the last restart are ever read.
`default_nettype none

module bitvector_rank_query_engine
  import brqe_pkg::*;
#(
  parameter int MAX_BITS        = DEF_MAX_BITS,
  parameter int SAMPLE_INTERVAL = DEF_SAMPLE_INTERVAL
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               req_type,
  input  wire logic               first_word,
  input  wire logic               last_word,
  input  wire logic [WORD_W-1:0]  word_bits,
  input  wire logic [VALID_W-1:0] valid_bits,
  input  wire logic [POS_W-1:0]   position,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [SHIFT_W-1:0]      shift,
  output logic                    position_pruned,
  output logic                    beyond_length
);

  localparam int NUM_WORDS   = MAX_BITS / WORD_W;
  localparam int NUM_SAMPLES = (MAX_BITS + SAMPLE_INTERVAL - 1) / SAMPLE_INTERVAL;
  localparam int AW          = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int SW          = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
  localparam int WI_W        = $clog2(NUM_WORDS + 1);
  localparam int LEN_W       = $clog2(MAX_BITS + 1);
  localparam int SL          = $clog2(SAMPLE_INTERVAL);
  localparam int WL          = SL - BIT_W;
  localparam int WPS         = SAMPLE_INTERVAL / WORD_W;
  localparam logic [AW-1:0] IVL_MASK = AW'(WPS - 1);

  state_t state;
  state_t state_next;

  logic [WI_W-1:0]    load_word_index;
  logic [SHIFT_W-1:0] total_ones;
  logic [LEN_W-1:0]   vector_length;

  logic               l_first;
  logic               l_last;
  logic [WORD_W-1:0]  l_word;
  logic [VALID_W-1:0] l_valid;
  logic [POS_W-1:0]   q_pos;

  logic [AW-1:0]      rd_ptr;
  logic               rd_first;
  logic [SHIFT_W-1:0] rank;

  logic [SHIFT_W-1:0] res_shift;
  logic               res_pruned;
  logic               res_beyond;

  logic               in_xfer;
  logic               out_free;

  logic [WI_W-1:0]    eff_idx;
  logic [SHIFT_W-1:0] eff_total;
  logic [LEN_W-1:0]   eff_len;
  logic               store_full;
  logic [VALID_W-1:0] valid_eff;
  logic [WORD_W-1:0]  word_mask;
  logic [WORD_W-1:0]  word_m;
  logic [AW-1:0]      ld_addr;
  logic [SHIFT_W-1:0] ld_total;
  logic [LEN_W-1:0]   ld_len;

  logic [AW-1:0]      q_word;
  logic [BIT_W-1:0]   q_bit;
  logic [SW-1:0]      q_sample;
  logic [AW-1:0]      q_start;
  logic               q_beyond;
  logic               q_last_word;
  logic [SHIFT_W-1:0] q_base;
  logic [SHIFT_W-1:0] q_sum;

  logic               bs_we;
  logic [AW-1:0]      bs_raddr;
  logic [WORD_W-1:0]  bs_rdata;
  logic               rs_we;
  logic [SW-1:0]      rs_waddr;
  logic [SHIFT_W-1:0] rs_rdata;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // load datapath
  always_comb begin
    eff_idx    = l_first ? '0 : load_word_index;
    eff_total  = l_first ? '0 : total_ones;
    eff_len    = l_first ? '0 : vector_length;
    store_full = (eff_idx >= WI_W'(NUM_WORDS));
    if (!l_last) begin
      valid_eff = VALID_W'(WORD_W);
    end else if (l_valid > VALID_W'(WORD_W)) begin
      valid_eff = VALID_W'(WORD_W);
    end else begin
      valid_eff = l_valid;
    end
    if (valid_eff >= VALID_W'(WORD_W)) begin
      word_mask = '1;
    end else begin
      word_mask = (WORD_W'(1) << valid_eff) - WORD_W'(1);
    end
    word_m   = l_word & word_mask;
    ld_addr  = eff_idx[AW-1:0];
    ld_total = eff_total + SHIFT_W'(popcount64(word_m));
    ld_len   = LEN_W'({ld_addr, {BIT_W{1'b0}}}) + LEN_W'(valid_eff);
  end

  // query datapath
  always_comb begin
    q_word      = q_pos[BIT_W +: AW];
    q_bit       = q_pos[BIT_W-1:0];
    q_sample    = SW'(q_pos >> SL);
    q_start     = q_word & ~IVL_MASK;
    q_beyond    = (q_pos >= POS_W'(vector_length));
    q_last_word = (rd_ptr == q_word);
    q_base      = rd_first ? rs_rdata : rank;
    if (q_last_word) begin
      q_sum = q_base + SHIFT_W'(popcount64(bs_rdata &
                                ((WORD_W'(1) << q_bit) - WORD_W'(1))));
    end else begin
      q_sum = q_base + SHIFT_W'(popcount64(bs_rdata));
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = (req_type == REQ_LOAD) ? ST_LOAD : ST_QSTART;
        end
      end
      ST_LOAD:   state_next = ST_FINISH;
      ST_QSTART: state_next = q_beyond ? ST_FINISH : ST_QRUN;
      ST_QRUN: begin
        if (q_last_word) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    bs_we    = 1'b0;
    rs_we    = 1'b0;
    bs_raddr = rd_ptr + AW'(1);
    rs_waddr = SW'(ld_addr >> WL);
    case (state)
      ST_IDLE:   in_stall = 1'b0;
      ST_LOAD: begin
        bs_we = !store_full;
        rs_we = !store_full && ((ld_addr & IVL_MASK) == '0);
      end
      ST_QSTART: bs_raddr = q_start;
      ST_QRUN:   bs_raddr = rd_ptr + AW'(1);
      ST_FINISH: in_stall = 1'b1;
      default:   in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_word_index <= '0;
      total_ones      <= '0;
      vector_length   <= '0;
    end else if (state == ST_LOAD) begin
      if (store_full) begin
        load_word_index <= eff_idx;
        total_ones      <= eff_total;
        vector_length   <= eff_len;
      end else begin
        load_word_index <= eff_idx + WI_W'(1);
        total_ones      <= ld_total;
        vector_length   <= ld_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      l_first <= first_word;
      l_last  <= last_word;
      l_word  <= word_bits;
      l_valid <= valid_bits;
      q_pos   <= position;
    end
    case (state)
      ST_LOAD: begin
        res_shift  <= store_full ? eff_total : ld_total;
        res_pruned <= 1'b0;
        res_beyond <= 1'b0;
      end
      ST_QSTART: begin
        rd_ptr     <= q_start;
        rd_first   <= 1'b1;
        res_shift  <= total_ones;
        res_pruned <= 1'b0;
        res_beyond <= 1'b1;
      end
      ST_QRUN: begin
        rd_ptr     <= rd_ptr + AW'(1);
        rd_first   <= 1'b0;
        rank       <= q_sum;
        res_shift  <= q_sum;
        res_pruned <= bs_rdata[q_bit];
        res_beyond <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      shift           <= res_shift;
      position_pruned <= res_pruned;
      beyond_length   <= res_beyond;
    end
  end

  brqe_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_WORDS),
    .AW    (AW)
  ) u_bit_store (
    .clk   (clk),
    .we    (bs_we),
    .waddr (ld_addr),
    .wdata (word_m),
    .raddr (bs_raddr),
    .rdata (bs_rdata)
  );

  brqe_ram #(
    .WIDTH (SHIFT_W),
    .DEPTH (NUM_SAMPLES),
    .AW    (SW)
  ) u_rank_samples (
    .clk   (clk),
    .we    (rs_we),
    .waddr (rs_waddr),
    .wdata (eff_total),
    .raddr (q_sample),
    .rdata (rs_rdata)
  );

`ifndef SYNTHESIS
  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result shown without a finished item");

  a_scan_bounded: assert property (@(posedge clk) disable iff (rst)
    state == ST_QRUN |-> rd_ptr <= q_word)
    else $error("word scan passed the query word");

  a_len_bounded: assert property (@(posedge clk) disable iff (rst)
    vector_length <= LEN_W'(MAX_BITS) && load_word_index <= WI_W'(NUM_WORDS))
    else $error("vector length or word index out of range");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(position_pruned && beyond_length))
    else $error("pruned and beyond flags both set");
`endif

endmodule

`default_nettype wire

### design/brqe_ram.sv
// ----------------------------------------------------------------------------
// brqe_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module brqe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
